[rtl/knn_pkg.sv]
// Shared types, constants and helpers for the k-th neighbour distance core.
package knn_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int DIMS       = 3;

  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 10;
  localparam int IN_COORD_W = 16;
  localparam int DIST_W     = 36;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = (SQ_W + 2 > DIST_W) ? SQ_W + 2 : DIST_W;

  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int PCOUNT_W   = 11;
  localparam int RANK_W     = 10;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd1024;
  localparam logic [RANK_W-1:0]   RANK_RESET   = 10'd1;

  localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEIGHBOUR_RANK = 1'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic                         opcode;
    logic [IDX_W-1:0]             point_index;
    logic signed [IN_COORD_W-1:0] coord_x;
    logic signed [IN_COORD_W-1:0] coord_y;
    logic signed [IN_COORD_W-1:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] kth_distance;
    logic              no_neighbour;
  } out_word_t;

  typedef struct packed {
    logic [DIMS-1:0][COORD_BITS-1:0] c;
  } pt_t;

  // classified command as it sits between front and back
  typedef struct packed {
    logic              is_query;
    logic              idx_ok;
    logic [ADDR_W-1:0] addr;
    pt_t               pt;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic excl;
    pt_t  self_pt;
    pt_t  other_pt;
  } dist_req_t;

  typedef struct packed {
    logic              valid;
    logic              excl;
    logic [DIST_W-1:0] sq_dist;
  } dist_res_t;

  // wrap or sign-extend a 16-bit input coordinate to the stored width
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [IN_COORD_W-1:0] raw);
    logic signed [31:0] ext;
    ext = 32'($signed(raw));
    return ext[COORD_BITS-1:0];
  endfunction

endpackage

[rtl/knn_cmd_queue.sv]
// Front end: classifies incoming words and queues them for the executor.
module knn_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  knn_pkg::in_word_t in_word,
  output logic              in_full,
  output logic              cmd_valid,
  output knn_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  knn_pkg::cmd_t                q_r [knn_pkg::QDEPTH];
  logic [knn_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [knn_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [knn_pkg::QPTR_W:0]     count_r, count_nxt;
  knn_pkg::cmd_t                cls;
  logic                         do_push, do_pop;

  always_comb begin
    cls.is_query = (in_word.opcode == knn_pkg::OP_QUERY);
    cls.idx_ok   = (32'(in_word.point_index) < 32'(knn_pkg::MAX_POINTS));
    cls.addr     = knn_pkg::ADDR_W'(in_word.point_index);
    cls.pt.c[0]  = knn_pkg::to_coord(in_word.coord_x);
    cls.pt.c[1]  = knn_pkg::to_coord(in_word.coord_y);
    cls.pt.c[2]  = knn_pkg::to_coord(in_word.coord_z);
  end

  assign in_full   = (count_r == (knn_pkg::QPTR_W+1)'(knn_pkg::QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[rtl/knn_dist_pipe.sv]
// Three-stage squared Euclidean distance pipeline: |diff|, square, sum and saturate.
module knn_dist_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  knn_pkg::dist_req_t  req,
  output knn_pkg::dist_res_t  res
);

  logic                                          v1_r, v2_r, v3_r;
  logic                                          ex1_r, ex2_r, ex3_r;
  logic [knn_pkg::DIMS-1:0][knn_pkg::MAG_W-1:0]  mag_r, mag_nxt;
  logic [knn_pkg::DIMS-1:0][knn_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [knn_pkg::DIST_W-1:0]                    dist_r, dist_nxt;
  logic [knn_pkg::SUM_W-1:0]                     sum;

  always_comb begin
    logic signed [knn_pkg::MAG_W-1:0] diff;
    for (int d = 0; d < knn_pkg::DIMS; d++) begin
      diff = $signed({req.self_pt.c[d][knn_pkg::COORD_BITS-1], req.self_pt.c[d]})
           - $signed({req.other_pt.c[d][knn_pkg::COORD_BITS-1], req.other_pt.c[d]});
      // the difference of two sign-extended coordinates never reaches the most
      // negative value, so negating it gives the right unsigned magnitude
      mag_nxt[d] = diff[knn_pkg::MAG_W-1] ? knn_pkg::MAG_W'(-diff) : knn_pkg::MAG_W'(diff);
      sq_nxt[d]  = mag_r[d] * mag_r[d];
    end
    sum = '0;
    for (int d = 0; d < knn_pkg::DIMS; d++) begin
      sum = sum + knn_pkg::SUM_W'(sq_r[d]);
    end
    dist_nxt = (sum > knn_pkg::SUM_W'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX
                                                          : knn_pkg::DIST_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ex1_r  <= req.excl;
    ex2_r  <= ex1_r;
    ex3_r  <= ex2_r;
    mag_r  <= mag_nxt;
    sq_r   <= sq_nxt;
    dist_r <= dist_nxt;
  end

  assign res.valid   = v3_r;
  assign res.excl    = ex3_r;
  assign res.sq_dist = dist_r;

endmodule

[rtl/knn_exec.sv]
// Back end: point store, distance scan sequencer and bitwise rank selection.
module knn_exec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  knn_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic [knn_pkg::CNT_W-1:0] n_cfg,
  input  logic [knn_pkg::RANK_W-1:0] k_cfg,
  output logic                      res_valid,
  output knn_pkg::out_word_t        res,
  input  logic                      res_busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELF_RD,
    S_SELF_CAP,
    S_PASS,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  knn_pkg::pt_t                 mem [knn_pkg::MAX_POINTS];
  knn_pkg::pt_t                 rd_data_r;
  logic [knn_pkg::ADDR_W-1:0]   rd_addr;
  logic                         mem_we;

  logic                         q_ok_r, q_ok_nxt;
  logic [knn_pkg::ADDR_W-1:0]   q_addr_r, q_addr_nxt;
  knn_pkg::pt_t                 self_r, self_nxt;
  logic [knn_pkg::CNT_W-1:0]    j_r, j_nxt;
  logic [knn_pkg::CNT_W-1:0]    recv_r, recv_nxt;
  logic [knn_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [knn_pkg::CNT_W-1:0]    krem_r, krem_nxt;
  logic [knn_pkg::DIST_W-1:0]   pfx_r, pfx_nxt;
  logic [knn_pkg::DIST_W-1:0]   mask_r, mask_nxt;
  logic [knn_pkg::DIST_W-1:0]   bsel_r, bsel_nxt;
  logic                         none_r, none_nxt;
  logic                         mem_v_r, mem_v_nxt;
  logic                         mem_ex_r, mem_ex_nxt;

  knn_pkg::dist_req_t           dreq;
  knn_pkg::dist_res_t           dres;

  logic                         issue, hit, pass_end, self_excl;
  logic [knn_pkg::CNT_W-1:0]    cnt_fin, m_val;
  logic [knn_pkg::RANK_W-1:0]   k_eff;

  knn_dist_pipe u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .res   (dres)
  );

  assign dreq.valid    = mem_v_r;
  assign dreq.excl     = mem_ex_r;
  assign dreq.self_pt  = self_r;
  assign dreq.other_pt = rd_data_r;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;
  assign mem_we  = cmd_pop && !cmd.is_query && cmd.idx_ok;
  assign issue   = (state_r == S_PASS) && (j_r < n_cfg);
  assign rd_addr = issue ? j_r[knn_pkg::ADDR_W-1:0] : q_addr_r;

  // count a distance that shares the decided prefix and has a zero at the current bit
  assign hit = dres.valid && !dres.excl
            && (((dres.sq_dist ^ pfx_r) & mask_r) == '0)
            && ((dres.sq_dist & bsel_r) == '0);
  assign cnt_fin  = hit ? cnt_r + 1'b1 : cnt_r;
  assign pass_end = (state_r == S_PASS) && dres.valid && (recv_r == n_cfg - 1'b1);

  assign self_excl = q_ok_r && (knn_pkg::CNT_W'(q_addr_r) < n_cfg);
  assign m_val     = self_excl ? n_cfg - 1'b1 : n_cfg;
  assign k_eff     = (k_cfg == '0) ? knn_pkg::RANK_W'(1) : k_cfg;

  assign res_valid        = (state_r == S_DONE) && !res_busy;
  assign res.kth_distance = none_r ? knn_pkg::DIST_MAX : pfx_r;
  assign res.no_neighbour = none_r;

  always_comb begin
    state_nxt  = state_r;
    q_ok_nxt   = q_ok_r;
    q_addr_nxt = q_addr_r;
    self_nxt   = self_r;
    j_nxt      = j_r;
    recv_nxt   = recv_r;
    cnt_nxt    = cnt_r;
    krem_nxt   = krem_r;
    pfx_nxt    = pfx_r;
    mask_nxt   = mask_r;
    bsel_nxt   = bsel_r;
    none_nxt   = none_r;
    mem_v_nxt  = issue;
    mem_ex_nxt = q_ok_r && (j_r[knn_pkg::ADDR_W-1:0] == q_addr_r);

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd.is_query) begin
          q_ok_nxt   = cmd.idx_ok;
          q_addr_nxt = cmd.addr;
          state_nxt  = S_SELF_RD;
        end
      end
      S_SELF_RD: begin
        state_nxt = S_SELF_CAP;
      end
      S_SELF_CAP: begin
        self_nxt = q_ok_r ? rd_data_r : '0;
        j_nxt    = '0;
        recv_nxt = '0;
        cnt_nxt  = '0;
        pfx_nxt  = '0;
        mask_nxt = '0;
        bsel_nxt = {1'b1, {(knn_pkg::DIST_W-1){1'b0}}};
        none_nxt = (32'(k_eff) > 32'(m_val));
        krem_nxt = knn_pkg::CNT_W'(k_eff);
        state_nxt = none_nxt ? S_DONE : S_PASS;
      end
      S_PASS: begin
        if (issue) begin
          j_nxt = j_r + 1'b1;
        end
        if (dres.valid) begin
          recv_nxt = recv_r + 1'b1;
        end
        cnt_nxt = cnt_fin;
        if (pass_end) begin
          if (krem_r > cnt_fin) begin
            pfx_nxt  = pfx_r | bsel_r;
            krem_nxt = krem_r - cnt_fin;
          end
          // advance to the next lower bit, or finish after bit zero
          mask_nxt = mask_r | bsel_r;
          bsel_nxt = bsel_r >> 1;
          j_nxt    = '0;
          recv_nxt = '0;
          cnt_nxt  = '0;
          if (bsel_r[0]) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!res_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mem_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mem_v_r <= mem_v_nxt;
    end
    q_ok_r   <= q_ok_nxt;
    q_addr_r <= q_addr_nxt;
    self_r   <= self_nxt;
    j_r      <= j_nxt;
    recv_r   <= recv_nxt;
    cnt_r    <= cnt_nxt;
    krem_r   <= krem_nxt;
    pfx_r    <= pfx_nxt;
    mask_r   <= mask_nxt;
    bsel_r   <= bsel_nxt;
    none_r   <= none_nxt;
    mem_ex_r <= mem_ex_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr] <= cmd.pt;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[rtl/knn_kth_distance_core.sv]
// Top level: configuration registers, front queue, executor and result register.
//
// Stores up to 1024 3D points (signed Q8.8) and answers queries with the k-th
// smallest squared distance (unsigned Q20.16) from the queried point to the
// other points among the first point_count slots. A load word is written to the
// point store when the executor takes it. A query first reads its own point,
// then scans the point store once per distance bit, deciding one bit of the
// answer per scan from the count of distances below the current threshold;
// the point store has a single read port. When fewer than k neighbours exist
// the scans are skipped and the answer is all ones with no_neighbour set. A
// four-word queue in front lets words be pushed while a query runs, and a
// one-word result register lets the next word start while a result waits to
// be popped.
// Configuration must be written only while the block is idle.
module knn_kth_distance_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  knn_pkg::in_word_t             in_word,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output knn_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [knn_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [knn_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [knn_pkg::PCOUNT_W-1:0] pcount_r;
  logic [knn_pkg::RANK_W-1:0]   rank_r;
  logic [knn_pkg::CNT_W-1:0]    n_eff;
  logic                         out_valid_r;
  knn_pkg::out_word_t           out_r;
  logic                         cmd_valid, cmd_pop, res_valid;
  knn_pkg::cmd_t                cmd;
  knn_pkg::out_word_t           res;

  knn_cmd_queue u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  knn_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .n_cfg     (n_eff),
    .k_cfg     (rank_r),
    .res_valid (res_valid),
    .res       (res),
    .res_busy  (out_valid_r)
  );

  // clamp the count to the store depth
  assign n_eff = (32'(pcount_r) > 32'(knn_pkg::MAX_POINTS))
               ? knn_pkg::CNT_W'(knn_pkg::MAX_POINTS)
               : knn_pkg::CNT_W'(pcount_r);

  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= knn_pkg::PCOUNT_RESET;
      rank_r      <= knn_pkg::RANK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          knn_pkg::CFG_POINT_COUNT:    pcount_r <= cfg_wdata[knn_pkg::PCOUNT_W-1:0];
          knn_pkg::CFG_NEIGHBOUR_RANK: rank_r   <= cfg_wdata[knn_pkg::RANK_W-1:0];
          default: begin
          end
        endcase
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

endmodule

[tb/tb_knn_kth_distance_core.sv]
// Testbench for the k-th nearest neighbour distance core: directed and random load/query words.
module tb_knn_kth_distance_core;
  timeunit 1ns;
  timeprecision 1ps;

  import knn_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int WIDE_SLOTS = 128;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  in_word_t              in_word = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // local copy of the block's state
  in_word_t              slot_copy [MAX_POINTS];
  bit                    slot_set [MAX_POINTS];
  int                    written_slots [$];
  logic [PCOUNT_W-1:0]   count_reg = PCOUNT_RESET;
  logic [RANK_W-1:0]     rank_reg = RANK_RESET;
  logic [DIST_W-1:0]     dist_buf [MAX_POINTS];

  out_word_t             queued_answers [$];

  int send_idle_pct = 0;
  int pop_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int answers_checked = 0;
  int full_cycles = 0;
  int quiet_cycles = 0;

  knn_kth_distance_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [DIST_W-1:0] squared_gap(input in_word_t p, input in_word_t q);
    longint dx, dy, dz;
    dx = longint'($signed(p.coord_x)) - longint'($signed(q.coord_x));
    dy = longint'($signed(p.coord_y)) - longint'($signed(q.coord_y));
    dz = longint'($signed(p.coord_z)) - longint'($signed(q.coord_z));
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // k-th smallest distance from the queried slot to the other counted slots
  function automatic out_word_t kth_distance_of(input logic [IDX_W-1:0] idx);
    int n, k, m, a, b, below, at_or_below;
    out_word_t ans;
    n = (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
    k = (rank_reg == 0) ? 1 : int'(rank_reg);
    m = 0;
    ans.kth_distance = DIST_MAX;
    ans.no_neighbour = 1'b1;
    for (a = 0; a < n; a++) begin
      if (a != int'(idx)) begin
        dist_buf[m] = squared_gap(slot_copy[idx], slot_copy[a]);
        m++;
      end
    end
    if (k <= m) begin
      // ties count as separate entries: pick the value whose rank window holds k
      for (a = 0; a < m && ans.no_neighbour; a++) begin
        below = 0;
        at_or_below = 0;
        for (b = 0; b < m; b++) begin
          if (dist_buf[b] < dist_buf[a]) below++;
          if (dist_buf[b] <= dist_buf[a]) at_or_below++;
        end
        if (below < k && k <= at_or_below) begin
          ans.kth_distance = dist_buf[a];
          ans.no_neighbour = 1'b0;
        end
      end
    end
    return ans;
  endfunction

  function automatic logic [IN_COORD_W-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return IN_COORD_W'($urandom);
    if (sel < 7) return IN_COORD_W'(int'($urandom_range(0, 8)) - 4);
    if (sel == 7) return 16'h7FFF;
    if (sel == 8) return 16'h8000;
    return IN_COORD_W'(int'($urandom_range(0, 6)) - 3) << 8;
  endfunction

  function automatic in_word_t make_load(input int idx, input logic [IN_COORD_W-1:0] x,
                                         input logic [IN_COORD_W-1:0] y,
                                         input logic [IN_COORD_W-1:0] z);
    in_word_t w;
    w.opcode = OP_LOAD;
    w.point_index = IDX_W'(idx);
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    return w;
  endfunction

  // random point, now and then a copy of a stored one to force ties
  function automatic in_word_t random_load(input int idx);
    in_word_t src;
    if (written_slots.size() != 0 && $urandom_range(0, 4) == 0) begin
      src = slot_copy[written_slots[$urandom_range(0, written_slots.size() - 1)]];
      return make_load(idx, src.coord_x, src.coord_y, src.coord_z);
    end
    return make_load(idx, pick_coord(), pick_coord(), pick_coord());
  endfunction

  function automatic in_word_t make_query(input int idx);
    in_word_t w;
    w.opcode = OP_QUERY;
    w.point_index = IDX_W'(idx);
    w.coord_x = IN_COORD_W'($urandom);
    w.coord_y = IN_COORD_W'($urandom);
    w.coord_z = IN_COORD_W'($urandom);
    return w;
  endfunction

  task automatic apply_word(input in_word_t w);
    if (w.opcode == OP_LOAD) begin
      slot_copy[w.point_index] = w;
      if (!slot_set[w.point_index]) begin
        slot_set[w.point_index] = 1'b1;
        written_slots.push_back(int'(w.point_index));
      end
      loads_sent++;
    end else begin
      queued_answers.push_back(kth_distance_of(w.point_index));
      queries_sent++;
    end
  endtask

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_full);
    apply_word(w);
  endtask

  // drop push, drain all answers, then let trailing loads retire
  task automatic wait_idle();
    @(negedge clk);
    in_push = 1'b0;
    while (queued_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    if (addr == CFG_POINT_COUNT) count_reg = data[PCOUNT_W-1:0];
    else rank_reg = data[RANK_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int count, input int rank);
    wait_idle();
    write_reg(CFG_POINT_COUNT, CFG_W'(count));
    write_reg(CFG_NEIGHBOUR_RANK, CFG_W'(rank));
  endtask

  task automatic check_answer(input out_word_t got);
    out_word_t want;
    if (queued_answers.size() == 0) begin
      $error("unexpected result word: kth_distance %0h no_neighbour %0b",
             got.kth_distance, got.no_neighbour);
      errors++;
    end else begin
      want = queued_answers.pop_front();
      answers_checked++;
      if (got.kth_distance !== want.kth_distance) begin
        $error("kth_distance: expected %0h, got %0h", want.kth_distance, got.kth_distance);
        errors++;
      end
      if (got.no_neighbour !== want.no_neighbour) begin
        $error("no_neighbour: expected %0b, got %0b", want.no_neighbour, got.no_neighbour);
        errors++;
      end
    end
  endtask

  // result side: random pops, held off while hold_cycles runs down
  initial begin
    forever begin
      @(negedge clk);
      out_pop = (hold_cycles == 0) && ($urandom_range(0, 99) >= pop_idle_pct);
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_answer(out_word);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) hold_cycles--;
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_push && in_full) full_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_directed();
    send_idle_pct = 0;
    pop_idle_pct = 0;
    configure(4, 1);
    send_word(make_load(0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_word(make_load(1, 16'h8000, 16'h8000, 16'h8000));
    send_word(make_load(2, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_load(3, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_load(1023, 16'h0100, 16'hFF00, 16'h0080));
    send_word(make_query(0));
    send_word(make_query(2));      // duplicate point: zero distance
    send_word(make_query(1023));   // outside the count, nothing left out
    configure(4, 3);
    send_word(make_query(2));
    send_word(make_query(1023));
    configure(4, 4);
    send_word(make_query(2));      // one neighbour short
    send_word(make_query(1023));
    configure(4, 0);               // rank zero acts as closest
    send_word(make_query(0));
    configure(0, 1);
    send_word(make_query(0));
    configure(1, 1);
    send_word(make_query(0));
    send_word(make_query(1023));
    configure(4, 1023);
    send_word(make_query(1));
  endtask

  task automatic run_segment(input int items);
    int n, k, sel, idx, j;
    sel = $urandom_range(0, 19);
    if (sel == 0) n = 0;
    else if (sel < 3) n = $urandom_range(17, 64);
    else n = $urandom_range(1, 16);
    sel = $urandom_range(0, 9);
    if (sel == 0) k = 0;
    else if (sel == 1) k = n + int'($urandom_range(1, 3));
    else if (sel == 2) k = (n > 1) ? n - 1 : 1;
    else k = $urandom_range(1, (n > 1) ? n - 1 : 1);
    configure(n, k);
    // every counted slot must hold a point before it is queried
    for (j = 0; j < n; j++) begin
      if (!slot_set[j]) send_word(random_load(j));
    end
    repeat (items) begin
      if ($urandom_range(0, 99) < 45) begin
        if (n > 0 && $urandom_range(0, 9) < 8) idx = $urandom_range(0, n - 1);
        else idx = written_slots[$urandom_range(0, written_slots.size() - 1)];
        send_word(make_query(idx));
      end else begin
        if ($urandom_range(0, 9) < 8) idx = $urandom_range(0, n + 7);
        else idx = $urandom_range(0, MAX_POINTS - 1);
        send_word(random_load(idx));
      end
    end
  endtask

  task automatic test_random();
    send_idle_pct = 38;
    pop_idle_pct = 60;
    repeat (4) run_segment(36);
    send_idle_pct = 60;
    pop_idle_pct = 38;
    repeat (4) run_segment(36);
    send_idle_pct = 0;
    pop_idle_pct = 0;
    repeat (4) run_segment(36);
  endtask

  // hold the result side long enough for the front queue to fill
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_idle_pct = 0;
    configure(2, 1);
    @(posedge clk);
    hold_cycles = 3000;
    repeat (12) send_word(make_query($urandom_range(0, 1)));
    wait_idle();
  endtask

  // a wider count with the highest ranks it allows
  task automatic test_wide_count();
    int j;
    send_idle_pct = 0;
    pop_idle_pct = 0;
    for (j = 0; j < WIDE_SLOTS; j++) begin
      if (!slot_set[j]) send_word(random_load(j));
    end
    configure(WIDE_SLOTS, $urandom_range(1, WIDE_SLOTS - 1));
    send_word(make_query($urandom_range(0, WIDE_SLOTS - 1)));
    configure(WIDE_SLOTS, WIDE_SLOTS - 1);
    send_word(make_query($urandom_range(0, WIDE_SLOTS - 1)));
    configure(WIDE_SLOTS, WIDE_SLOTS);   // outside the count: every slot is a neighbour
    send_word(make_query(MAX_POINTS - 1));
    send_word(make_query(0));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random();
    test_backpressure();
    test_wide_count();

    wait_idle();
    repeat (64) @(posedge clk);

    $display("Run covered %0d loads and %0d queries; %0d answers checked, %0d errors.",
             loads_sent, queries_sent, answers_checked, errors);
    $display("Counts 0..128, ranks 0..1023, three idle mixes; input held full %0d cycles.",
             full_cycles);
    if (errors == 0 && queued_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
